FILE: src/fca_pkg.sv
// ---------------------------------------------------------------------------
// fca_pkg: shared types and constants for the correlator accumulator
// Holds the field widths, the twiddle table, the state type and the
// request that passes from the frame front end to the transform back end.
// ---------------------------------------------------------------------------
package fca_pkg;

    localparam int SAMPLE_W = 16;
    localparam int WORK_W   = 24;
    localparam int PROD_W   = 2 * WORK_W;
    localparam int ACC_W    = 54;
    localparam int IDX_W    = 6;
    localparam int DEPTH    = 64;
    localparam int TW_W     = 16;
    localparam int SUM_W    = 48;

    localparam logic [0:0] REG_FRAMES = 1'b0;
    localparam logic [0:0] REG_POINTS = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DFT,
        ST_ROUND,
        ST_ACC,
        ST_EMIT
    } t_state;

    // one completed frame handed to the back end
    typedef struct packed {
        logic [2:0] p;
        logic       emit;
    } t_job;

    // cosine of j*2*pi/64 in Q15, capped at 32767
    function automatic logic signed [TW_W-1:0] twid_cos(input logic [5:0] j);
        logic [4:0]  m;
        logic        neg;
        logic [14:0] t;
        begin
            if (j <= 6'd16) begin
                m = j[4:0]; neg = 1'b0;
            end else if (j <= 6'd32) begin
                m = 5'(6'd32 - j); neg = 1'b1;
            end else if (j <= 6'd48) begin
                m = 5'(j - 6'd32); neg = 1'b1;
            end else begin
                m = 5'(7'd64 - {1'b0, j}); neg = 1'b0;
            end
            case (m)
                5'd0:  t = 15'd32767;
                5'd1:  t = 15'd32610;
                5'd2:  t = 15'd32138;
                5'd3:  t = 15'd31357;
                5'd4:  t = 15'd30274;
                5'd5:  t = 15'd28899;
                5'd6:  t = 15'd27246;
                5'd7:  t = 15'd25330;
                5'd8:  t = 15'd23170;
                5'd9:  t = 15'd20788;
                5'd10: t = 15'd18205;
                5'd11: t = 15'd15447;
                5'd12: t = 15'd12540;
                5'd13: t = 15'd9512;
                5'd14: t = 15'd6393;
                5'd15: t = 15'd3212;
                default: t = 15'd0;
            endcase
            twid_cos = neg ? -$signed({1'b0, t}) : $signed({1'b0, t});
        end
    endfunction

endpackage

FILE: src/fca_front.sv
// ---------------------------------------------------------------------------
// fca_front: frame capture
// Writes sample pairs into the frame store, counts pairs and frames and
// posts a job when a frame is complete. The top level holds off writes while busy.
// ---------------------------------------------------------------------------
module fca_front
    import fca_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr,
    input  logic signed [SAMPLE_W-1:0] i_sample_a,
    input  logic signed [SAMPLE_W-1:0] i_sample_b,
    input  logic [10:0]                i_frames,
    input  logic [2:0]                 i_points,
    input  logic                       i_job_full,
    output logic                       o_job_push,
    output t_job                       o_job,
    output logic [IDX_W-1:0]           o_wr_addr,
    output logic                       o_wr_en
);

    logic [6:0]  r_pair;
    logic [10:0] r_frames_done;
    logic [6:0]  n_pair;
    logic [2:0]  w_p;
    logic [6:0]  w_n;
    logic [10:0] w_target;
    logic [10:0] n_frames_done;

    always_comb begin
        w_p = (i_points < 3'd2) ? 3'd2 : ((i_points > 3'd6) ? 3'd6 : i_points);
        w_n = 7'(1) << w_p;
        w_target = (i_frames == 11'd0) ? 11'd1 : i_frames;
        n_pair = r_pair + 7'd1;
        n_frames_done = r_frames_done + 11'd1;
        o_wr_addr = r_pair[IDX_W-1:0];
        o_wr_en = i_wr;
        o_job_push = i_wr && (n_pair >= w_n);
        o_job.p = w_p;
        o_job.emit = n_frames_done >= w_target;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair <= '0;
            r_frames_done <= '0;
        end else if (i_wr) begin
            if (o_job_push) begin
                r_pair <= '0;
                r_frames_done <= o_job.emit ? 11'd0 : n_frames_done;
            end else begin
                r_pair <= n_pair;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_job_push && i_job_full)) else $error("job posted into full queue");
    a_pair_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_push |=> r_pair == 7'd0) else $error("pair count not cleared");
    a_pair_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pair < 7'd64) else $error("pair count out of range");
`endif

endmodule

FILE: src/fca_back.sv
// ---------------------------------------------------------------------------
// fca_back: transform and accumulate engine
// Direct DFT, one sample tap per channel per cycle (cosine and sine products), then rounding,
// power and cross accumulation per bin, then the output sweep when the job asks for it.
// ---------------------------------------------------------------------------
module fca_back
    import fca_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_job_valid,
    input  t_job                       i_job,
    output logic                       o_job_pop,
    input  logic                       i_wr_en,
    input  logic [IDX_W-1:0]           i_wr_addr,
    input  logic signed [SAMPLE_W-1:0] i_sample_a,
    input  logic signed [SAMPLE_W-1:0] i_sample_b,
    output logic                       o_busy,
    output logic                       o_valid,
    output logic [IDX_W-1:0]           o_bin_index,
    output logic [ACC_W-1:0]           o_power_a,
    output logic [ACC_W-1:0]           o_power_b,
    output logic signed [ACC_W-1:0]    o_cross_real,
    output logic signed [ACC_W-1:0]    o_cross_imag,
    output logic                       o_last_bin
);

    logic signed [SAMPLE_W-1:0] r_store_a [DEPTH];
    logic signed [SAMPLE_W-1:0] r_store_b [DEPTH];
    logic [ACC_W-1:0]           r_acc_pa [DEPTH];
    logic [ACC_W-1:0]           r_acc_pb [DEPTH];
    logic signed [ACC_W-1:0]    r_acc_cr [DEPTH];
    logic signed [ACC_W-1:0]    r_acc_ci [DEPTH];
    logic [DEPTH-1:0]           r_live;

    t_state r_state, n_state;
    t_job   r_job;
    logic [6:0] r_k, r_t, n_k, n_t;
    logic [3:0] r_sub, n_sub;
    logic signed [SUM_W-1:0] r_sar, r_sai, r_sbr, r_sbi;
    logic signed [SAMPLE_W-1:0] r_xa, r_xb;
    logic signed [WORK_W-1:0] r_ar, r_ai, r_br, r_bi;
    logic signed [TW_W-1:0] r_wc, r_ws;
    logic r_mv;
    logic signed [PROD_W-1:0] r_p0, r_p1, r_p2, r_p3;
    logic [ACC_W-1:0] r_rpa, r_rpb;
    logic signed [ACC_W-1:0] r_rcr, r_rci;
    logic r_rlive;
    logic [55:0] r_sum0, r_sum1;
    logic signed [55:0] r_sum2, r_sum3;
    logic [ACC_W-1:0] r_opa, r_opb;
    logic signed [ACC_W-1:0] r_ocr, r_oci;
    logic r_ov, r_olast, r_olive;
    logic [IDX_W-1:0] r_obin;

    logic [6:0] w_n;
    logic [5:0] w_j;
    logic       w_read;

    function automatic logic signed [WORK_W-1:0] rnd(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] q;
        begin
            q = (s + SUM_W'(16384)) >>> 15;
            if (q > SUM_W'(8388607)) rnd = 24'sh7fffff;
            else if (q < -SUM_W'(8388608)) rnd = 24'sh800000;
            else rnd = q[WORK_W-1:0];
        end
    endfunction

    assign w_n = 7'(1) << r_job.p;
    // twiddle index t*k*(64/N) mod 64
    assign w_j = 6'((r_t[5:0] * r_k[5:0]) << (3'd6 - r_job.p));
    assign w_read = (r_state == ST_DFT) && (r_t < w_n);

    always_comb begin
        n_state = r_state;
        n_k = r_k;
        n_t = r_t;
        n_sub = r_sub;
        o_job_pop = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_state = ST_DFT;
                    n_k = '0;
                    n_t = '0;
                end
            end
            ST_DFT: begin
                // run on past the last tap so the read and multiply stages drain
                n_t = r_t + 7'd1;
                if (r_t == w_n + 7'd2) n_state = ST_ROUND;
            end
            ST_ROUND: begin
                n_state = ST_ACC;
                n_sub = '0;
            end
            ST_ACC: begin
                n_sub = r_sub + 4'd1;
                if (r_sub == 4'd3) begin
                    n_t = '0;
                    if (r_k == w_n - 7'd1) begin
                        n_k = '0;
                        n_state = r_job.emit ? ST_EMIT : ST_IDLE;
                    end else begin
                        n_k = r_k + 7'd1;
                        n_state = ST_DFT;
                    end
                end
            end
            ST_EMIT: begin
                n_k = r_k + 7'd1;
                if (r_k == 7'(DEPTH - 1)) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k <= '0;
            r_t <= '0;
            r_sub <= '0;
            r_ov <= 1'b0;
            r_mv <= 1'b0;
            r_live <= '0;
        end else begin
            r_state <= n_state;
            r_k <= n_k;
            r_t <= n_t;
            r_sub <= n_sub;
            r_mv <= w_read;
            r_ov <= (r_state == ST_EMIT) && (r_k < w_n);
            if (r_state == ST_ACC && r_sub == 4'd3) r_live[r_k[IDX_W-1:0]] <= 1'b1;
            if (r_state == ST_EMIT) r_live[r_k[IDX_W-1:0]] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_store_a[i_wr_addr] <= i_sample_a;
            r_store_b[i_wr_addr] <= i_sample_b;
        end
        if (o_job_pop) r_job <= i_job;
        // stage 1: sample read and twiddle lookup
        r_xa <= r_store_a[r_t[IDX_W-1:0]];
        r_xb <= r_store_b[r_t[IDX_W-1:0]];
        r_wc <= twid_cos(w_j);
        r_ws <= twid_cos(6'(w_j + 6'd48));
        // stage 2: multiply-accumulate
        if (r_state == ST_DFT && r_t == 7'd0) begin
            r_sar <= '0; r_sai <= '0; r_sbr <= '0; r_sbi <= '0;
        end else if (r_mv) begin
            r_sar <= r_sar + SUM_W'(r_xa * r_wc);
            r_sai <= r_sai - SUM_W'(r_xa * r_ws);
            r_sbr <= r_sbr + SUM_W'(r_xb * r_wc);
            r_sbi <= r_sbi - SUM_W'(r_xb * r_ws);
        end
        if (r_state == ST_ROUND) begin
            r_ar <= rnd(r_sar); r_ai <= rnd(r_sai);
            r_br <= rnd(r_sbr); r_bi <= rnd(r_sbi);
        end
        if (r_state == ST_ACC) begin
            case (r_sub)
                4'd0: begin
                    // 24 x 24 signed products, sign-extended to the product width
                    r_p0 <= PROD_W'(r_ar) * PROD_W'(r_ar);
                    r_p1 <= PROD_W'(r_ai) * PROD_W'(r_ai);
                    r_p2 <= PROD_W'(r_br) * PROD_W'(r_br);
                    r_p3 <= PROD_W'(r_bi) * PROD_W'(r_bi);
                    r_rlive <= r_live[r_k[IDX_W-1:0]];
                    r_rpa <= r_acc_pa[r_k[IDX_W-1:0]];
                    r_rpb <= r_acc_pb[r_k[IDX_W-1:0]];
                    r_rcr <= r_acc_cr[r_k[IDX_W-1:0]];
                    r_rci <= r_acc_ci[r_k[IDX_W-1:0]];
                end
                4'd1: begin
                    r_sum0 <= 56'(unsigned'(r_p0)) + 56'(unsigned'(r_p1));
                    r_sum1 <= 56'(unsigned'(r_p2)) + 56'(unsigned'(r_p3));
                    r_p0 <= PROD_W'(r_ar) * PROD_W'(r_br);
                    r_p1 <= PROD_W'(r_ai) * PROD_W'(r_bi);
                    r_p2 <= PROD_W'(r_ai) * PROD_W'(r_br);
                    r_p3 <= PROD_W'(r_ar) * PROD_W'(r_bi);
                end
                4'd2: begin
                    r_sum0 <= r_sum0 + (r_rlive ? 56'(r_rpa) : 56'd0);
                    r_sum1 <= r_sum1 + (r_rlive ? 56'(r_rpb) : 56'd0);
                    r_sum2 <= (r_rlive ? 56'(r_rcr) : 56'sd0) + 56'(r_p0) + 56'(r_p1);
                    r_sum3 <= (r_rlive ? 56'(r_rci) : 56'sd0) + 56'(r_p2) - 56'(r_p3);
                end
                4'd3: begin
                    r_acc_pa[r_k[IDX_W-1:0]] <= (r_sum0[55:54] != 2'b00) ? '1 : r_sum0[53:0];
                    r_acc_pb[r_k[IDX_W-1:0]] <= (r_sum1[55:54] != 2'b00) ? '1 : r_sum1[53:0];
                    r_acc_cr[r_k[IDX_W-1:0]] <=
                        (r_sum2 > 56'sh1fffffffffffff) ? 54'sh1fffffffffffff :
                        (r_sum2 < -56'sh20000000000000) ? 54'sh20000000000000 :
                        r_sum2[53:0];
                    r_acc_ci[r_k[IDX_W-1:0]] <=
                        (r_sum3 > 56'sh1fffffffffffff) ? 54'sh1fffffffffffff :
                        (r_sum3 < -56'sh20000000000000) ? 54'sh20000000000000 :
                        r_sum3[53:0];
                end
                default: ;
            endcase
        end
        if (r_state == ST_EMIT) begin
            r_obin <= r_k[IDX_W-1:0];
            r_olast <= (r_k == w_n - 7'd1);
            r_olive <= r_live[r_k[IDX_W-1:0]];
            r_opa <= r_acc_pa[r_k[IDX_W-1:0]];
            r_opb <= r_acc_pb[r_k[IDX_W-1:0]];
            r_ocr <= r_acc_cr[r_k[IDX_W-1:0]];
            r_oci <= r_acc_ci[r_k[IDX_W-1:0]];
        end
    end

    assign o_busy = (r_state != ST_IDLE) || i_job_valid;
    assign o_valid = r_ov;
    assign o_bin_index = r_obin;
    assign o_power_a = r_olive ? r_opa : '0;
    assign o_power_b = r_olive ? r_opb : '0;
    assign o_cross_real = r_olive ? r_ocr : '0;
    assign o_cross_imag = r_olive ? r_oci : '0;
    assign o_last_bin = r_olast;

`ifndef SYNTHESIS
    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_k == 7'(DEPTH - 1)) |=> r_live == '0)
        else $error("accumulators not cleared after emit");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> r_state == ST_IDLE) else $error("job taken while running");
    a_valid_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_bin) |=> !o_valid) else $error("result after last bin");
`endif

endmodule

FILE: src/fx_correlator_accumulator_unit.sv
// ---------------------------------------------------------------------------
// fx_correlator_accumulator_unit: two-channel FX correlator top level
// Frame capture front end, one-entry job queue, DFT and accumulate back end.
// ---------------------------------------------------------------------------
// A request is taken while busy is low. The pair that completes
// a frame of N pairs raises busy for the direct DFT and accumulation of every bin,
// plus a sweep over all 64 bins that clears each one when a set is due.
// Results come from that sweep one a cycle, bins 0 to N-1; no stall.
// Synchronous active-low reset clears counts and accumulator valid bits.
module fx_correlator_accumulator_unit
    import fca_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [SAMPLE_W-1:0] i_sample_a,
    input  logic signed [SAMPLE_W-1:0] i_sample_b,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [0:0]                 i_cfg_index,
    input  logic [10:0]                i_cfg_data,
    output logic                       o_valid,
    output logic [IDX_W-1:0]           o_bin_index,
    output logic [ACC_W-1:0]           o_power_a,
    output logic [ACC_W-1:0]           o_power_b,
    output logic signed [ACC_W-1:0]    o_cross_real,
    output logic signed [ACC_W-1:0]    o_cross_imag,
    output logic                       o_last_bin
);

    logic [10:0] r_frames;
    logic [2:0]  r_points;
    logic        r_qv;
    t_job        r_qjob;
    logic        w_push, w_pop, w_back_busy, w_wr_en;
    t_job        w_job;
    logic [IDX_W-1:0] w_addr;

    assign o_cfg_ready = 1'b1;
    assign busy = w_back_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= 11'd4;
            r_points <= 3'd6;
            r_qv <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_FRAMES: r_frames <= i_cfg_data;
                    REG_POINTS: r_points <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (w_push) r_qv <= 1'b1;
            else if (w_pop) r_qv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_qjob <= w_job;
    end

    fca_front u_front (
        .i_clk, .i_rst_n,
        .i_wr(start && !busy),
        .i_sample_a, .i_sample_b,
        .i_frames(r_frames), .i_points(r_points),
        .i_job_full(r_qv),
        .o_job_push(w_push), .o_job(w_job),
        .o_wr_addr(w_addr), .o_wr_en(w_wr_en)
    );

    fca_back u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(r_qv), .i_job(r_qjob), .o_job_pop(w_pop),
        .i_wr_en(w_wr_en), .i_wr_addr(w_addr),
        .i_sample_a, .i_sample_b,
        .o_busy(w_back_busy),
        .o_valid, .o_bin_index, .o_power_a, .o_power_b,
        .o_cross_real, .o_cross_imag, .o_last_bin
    );

`ifndef SYNTHESIS
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> busy) else $error("busy low after frame complete");
    a_no_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy)) else $error("result without job");
    a_q_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && r_qv)) else $error("job queue overflow");
`endif

endmodule
